// ===== design/sha1sh_pkg.sv =====
// shared types and constants of the sha-1 stream hasher
`default_nettype none
package sha1sh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    typedef enum logic [2:0] {
        SCH_HOLD,
        SCH_BYTE,
        SCH_LEN,
        SCH_SHIFT,
        SCH_CLEAR
    } t_sch_op;

    typedef struct packed {
        t_sch_op    op;
        logic [5:0] pos;
    } t_sch_ctl;

    localparam int DIGEST_WORDS = 5;
    localparam int SCHED_WORDS  = 16;

    localparam logic [31:0] H_INIT [0:DIGEST_WORDS-1] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [6:0] ROUND_BAND_1 = 7'd20;
    localparam logic [6:0] ROUND_BAND_2 = 7'd40;
    localparam logic [6:0] ROUND_BAND_3 = 7'd60;
    localparam logic [6:0] LAST_ROUND   = 7'd79;

    localparam logic [7:0] PAD_BYTE       = 8'h80;
    localparam logic [5:0] PAD_LIMIT      = 6'd56;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX  = 3'd4;

endpackage
`default_nettype wire

// ===== design/sha1sh_sched.sv =====
// sixteen-word message schedule line with byte packing and length insertion
`default_nettype none
module sha1sh_sched (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sha1sh_pkg::t_sch_ctl i_ctl,
    input  wire logic [7:0]           i_byte,
    input  wire logic [63:0]          i_len,
    output logic [31:0]               o_w
);

    logic [31:0] r_words [0:sha1sh_pkg::SCHED_WORDS-1];
    logic [31:0] n_words [0:sha1sh_pkg::SCHED_WORDS-1];
    logic [31:0] w_mix;
    logic [4:0]  byte_shift;

    always_comb begin
        n_words    = r_words;
        w_mix      = r_words[0] ^ r_words[2] ^ r_words[8] ^ r_words[13];
        byte_shift = {~i_ctl.pos[1:0], 3'b000};
        case (i_ctl.op)
            sha1sh_pkg::SCH_HOLD: begin
            end
            sha1sh_pkg::SCH_BYTE: begin
                n_words[i_ctl.pos[5:2]] = r_words[i_ctl.pos[5:2]]
                                        | ({24'd0, i_byte} << byte_shift);
            end
            sha1sh_pkg::SCH_LEN: begin
                n_words[14] = i_len[63:32];
                n_words[15] = i_len[31:0];
            end
            sha1sh_pkg::SCH_SHIFT: begin
                for (int i = 0; i < sha1sh_pkg::SCHED_WORDS - 1; i++) begin
                    n_words[i] = r_words[i+1];
                end
                n_words[sha1sh_pkg::SCHED_WORDS-1] = {w_mix[30:0], w_mix[31]};
            end
            sha1sh_pkg::SCH_CLEAR: begin
                for (int i = 0; i < sha1sh_pkg::SCHED_WORDS; i++) begin
                    n_words[i] = 32'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sha1sh_pkg::SCHED_WORDS; i++) begin
                r_words[i] <= 32'd0;
            end
        end else begin
            r_words <= n_words;
        end
    end

    assign o_w = r_words[0];

endmodule
`default_nettype wire

// ===== design/sha1sh_round.sv =====
// shared sha-1 round unit: one round of the compression per use
`default_nettype none
module sha1sh_round (
    input  wire sha1sh_pkg::t_work i_work,
    input  wire logic [31:0]       i_w,
    input  wire logic [6:0]        i_round,
    output sha1sh_pkg::t_work      o_work
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] temp;

    always_comb begin
        if (i_round < sha1sh_pkg::ROUND_BAND_1) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = sha1sh_pkg::K_0;
        end else if (i_round < sha1sh_pkg::ROUND_BAND_2) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1sh_pkg::K_1;
        end else if (i_round < sha1sh_pkg::ROUND_BAND_3) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = sha1sh_pkg::K_2;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1sh_pkg::K_3;
        end
        temp     = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + k + i_w;
        o_work.a = temp;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule
`default_nettype wire

// ===== design/sha1_stream_hasher.sv =====
// top level of the sha-1 stream hasher: sequencer, chaining state and digest output
`default_nettype none
// Takes a message one byte per transaction and returns its SHA-1 digest as five
// transactions (H0 first) after the transaction marked end_of_message, which may
// carry no byte so that an empty message can be hashed. A byte that neither
// completes a 64-byte block nor ends the message leaves the input ready. The
// 64th byte of a block starts a compression that holds the input stalled through
// a load of the working variables, 80 passes through the single shared round
// unit, and an add of the result into the chaining state. The final transaction
// adds a padding step, a length step and one compression, or two when 56 or more
// bytes of the last block are pending, then the five digest words, one per cycle
// that the output is not stalled. The block then returns to the initial state for
// the next message. Lengths are counted in 64 bits and wrap as in the standard.
module sha1_stream_hasher (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire sha1sh_pkg::t_in_item  i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output sha1sh_pkg::t_out_item      o_out_item
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_LEN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_EXTRA,
        PH_FINAL
    } t_phase;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic               r_eom, n_eom;
    logic [63:0]        r_count, n_count;
    logic [6:0]         r_round, n_round;
    logic [2:0]         r_widx, n_widx;
    logic [31:0]        r_chain [0:sha1sh_pkg::DIGEST_WORDS-1];
    logic [31:0]        n_chain [0:sha1sh_pkg::DIGEST_WORDS-1];
    sha1sh_pkg::t_work  r_work, n_work;

    sha1sh_pkg::t_work    round_out;
    sha1sh_pkg::t_sch_ctl sch_ctl;
    logic [7:0]           sch_byte;
    logic [31:0]          sch_w;
    logic                 in_acc;

    assign in_acc = i_in_valid && (r_state == ST_IDLE);

    sha1sh_round u_round (
        .i_work  (r_work),
        .i_w     (sch_w),
        .i_round (r_round),
        .o_work  (round_out)
    );

    sha1sh_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sch_ctl),
        .i_byte  (sch_byte),
        .i_len   ({r_count[60:0], 3'b000}),
        .o_w     (sch_w)
    );

    always_comb begin
        sch_ctl.op  = sha1sh_pkg::SCH_HOLD;
        sch_ctl.pos = r_count[5:0];
        sch_byte    = i_in_item.data_byte;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_item.has_byte) begin
                    sch_ctl.op = sha1sh_pkg::SCH_BYTE;
                end
            end
            ST_ROUND: sch_ctl.op = sha1sh_pkg::SCH_SHIFT;
            ST_ADD:   sch_ctl.op = sha1sh_pkg::SCH_CLEAR;
            ST_PAD: begin
                sch_ctl.op = sha1sh_pkg::SCH_BYTE;
                sch_byte   = sha1sh_pkg::PAD_BYTE;
            end
            ST_LEN:   sch_ctl.op = sha1sh_pkg::SCH_LEN;
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_eom   = r_eom;
        n_count = r_count;
        n_round = r_round;
        n_widx  = r_widx;
        n_chain = r_chain;
        n_work  = r_work;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_eom = i_in_item.end_of_message;
                    if (i_in_item.has_byte) begin
                        n_count = r_count + 64'd1;
                    end
                    if (i_in_item.has_byte && (r_count[5:0] == sha1sh_pkg::BLOCK_LAST_POS)) begin
                        n_state = ST_LOAD;
                        n_phase = PH_DATA;
                    end else if (i_in_item.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_LOAD: begin
                n_work.a = r_chain[0];
                n_work.b = r_chain[1];
                n_work.c = r_chain[2];
                n_work.d = r_chain[3];
                n_work.e = r_chain[4];
                n_round  = 7'd0;
                n_state  = ST_ROUND;
            end
            ST_ROUND: begin
                n_work  = round_out;
                n_round = r_round + 7'd1;
                if (r_round == sha1sh_pkg::LAST_ROUND) begin
                    n_round = 7'd0;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_chain[0] = r_chain[0] + r_work.a;
                n_chain[1] = r_chain[1] + r_work.b;
                n_chain[2] = r_chain[2] + r_work.c;
                n_chain[3] = r_chain[3] + r_work.d;
                n_chain[4] = r_chain[4] + r_work.e;
                case (r_phase)
                    PH_DATA:  n_state = r_eom ? ST_PAD : ST_IDLE;
                    PH_EXTRA: n_state = ST_LEN;
                    PH_FINAL: begin
                        n_state = ST_OUT;
                        n_widx  = 3'd0;
                    end
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_PAD: begin
                if (r_count[5:0] >= sha1sh_pkg::PAD_LIMIT) begin
                    n_state = ST_LOAD;
                    n_phase = PH_EXTRA;
                end else begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_state = ST_LOAD;
                n_phase = PH_FINAL;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    if (r_widx == sha1sh_pkg::LAST_WORD_IDX) begin
                        n_state = ST_IDLE;
                        n_eom   = 1'b0;
                        n_count = 64'd0;
                        n_widx  = 3'd0;
                        n_chain = sha1sh_pkg::H_INIT;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_DATA;
            r_eom   <= 1'b0;
            r_count <= 64'd0;
            r_round <= 7'd0;
            r_widx  <= 3'd0;
            r_chain <= sha1sh_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_eom   <= n_eom;
            r_count <= n_count;
            r_round <= n_round;
            r_widx  <= n_widx;
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_in_stall              = (r_state != ST_IDLE);
    assign o_out_valid             = (r_state == ST_OUT);
    assign o_out_item.digest_word  = r_chain[r_widx];
    assign o_out_item.word_index   = r_widx;
    assign o_out_item.last_word    = (r_widx == sha1sh_pkg::LAST_WORD_IDX);

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while digest pending");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= sha1sh_pkg::LAST_ROUND)
        else $error("round counter out of range");

    a_ready_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.last_word) |=> !o_in_stall)
        else $error("not ready after final digest word");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.last_word) |=> (r_count == 64'd0))
        else $error("length not cleared for next message");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_sha1_stream_hasher.sv =====
// self-checking testbench of the sha-1 stream hasher: directed and random messages
`default_nettype none
module tb_sha1_stream_hasher;

    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 200;
    localparam int RANDOM_ITEMS = 500;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    sha1sh_pkg::t_in_item  in_item   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    sha1sh_pkg::t_out_item out_item;

    // digest predictor state
    logic [31:0]           hash_chain [0:sha1sh_pkg::DIGEST_WORDS-1];
    logic [31:0]           msg_block  [0:sha1sh_pkg::SCHED_WORDS-1];
    logic [63:0]           msg_bytes;
    sha1sh_pkg::t_out_item digest_q [$];

    int errors        = 0;
    int items_sent    = 0;
    int msgs_hashed   = 0;
    int words_checked = 0;
    int burst_left    = 0;
    bit pace_gaps     = 1'b1;
    int hold_seq      = 0;

    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_mode  = STALL_NONE;
    int mode_left   = 0;
    int stall_phase = 0;

    sha1_stream_hasher uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void hash_restart();
        for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) hash_chain[i] = sha1sh_pkg::H_INIT[i];
        for (int i = 0; i < sha1sh_pkg::SCHED_WORDS; i++) msg_block[i] = '0;
        msg_bytes = '0;
    endfunction

    function automatic void hash_compress();
        logic [31:0] a, b, c, d, e, f, k, w, tmp;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                w = msg_block[(t - 3) % 16] ^ msg_block[(t - 8) % 16]
                  ^ msg_block[(t - 14) % 16] ^ msg_block[t % 16];
                msg_block[t % 16] = {w[30:0], w[31]};
            end
            w = msg_block[t % 16];
            if (t < sha1sh_pkg::ROUND_BAND_1) begin
                f = (b & c) | (~b & d);
                k = sha1sh_pkg::K_0;
            end else if (t < sha1sh_pkg::ROUND_BAND_2) begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_1;
            end else if (t < sha1sh_pkg::ROUND_BAND_3) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1sh_pkg::K_2;
            end else begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
        for (int i = 0; i < sha1sh_pkg::SCHED_WORDS; i++) msg_block[i] = '0;
    endfunction

    function automatic void block_put(input logic [5:0] pos, input logic [7:0] v);
        msg_block[pos[5:2]] |= {24'h0, v} << (8 * (3 - pos[1:0]));
    endfunction

    function automatic void hash_take(input sha1sh_pkg::t_in_item it);
        logic [5:0]            pos;
        logic [63:0]           bits;
        sha1sh_pkg::t_out_item w;
        if (it.has_byte) begin
            pos = msg_bytes[5:0];
            block_put(pos, it.data_byte);
            msg_bytes++;
            if (pos == sha1sh_pkg::BLOCK_LAST_POS) hash_compress();
        end
        if (it.end_of_message) begin
            pos = msg_bytes[5:0];
            block_put(pos, sha1sh_pkg::PAD_BYTE);
            if (pos >= sha1sh_pkg::PAD_LIMIT) hash_compress();
            bits = msg_bytes << 3;
            msg_block[14] = bits[63:32];
            msg_block[15] = bits[31:0];
            hash_compress();
            for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
                w.digest_word = hash_chain[i];
                w.word_index  = i[2:0];
                w.last_word   = (i[2:0] == sha1sh_pkg::LAST_WORD_IDX);
                digest_q.push_back(w);
            end
            hash_restart();
        end
    endfunction

    function automatic sha1sh_pkg::t_in_item make_item(input logic [7:0] v, input logic has,
                                                       input logic last);
        sha1sh_pkg::t_in_item it;
        it.data_byte      = v;
        it.has_byte       = has;
        it.end_of_message = last;
        return it;
    endfunction

    always @(posedge clk) begin : monitor
        sha1sh_pkg::t_out_item want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                hash_take(in_item);
                if (in_item.end_of_message) msgs_hashed++;
            end
            if (out_valid && !out_stall) begin
                if (digest_q.size() == 0) begin
                    $error("digest word %h with no transaction expected",
                           out_item.digest_word);
                    errors++;
                end else begin
                    want = digest_q.pop_front();
                    words_checked++;
                    if (out_item.digest_word !== want.digest_word) begin
                        $error("digest_word: expected %h, got %h",
                               want.digest_word, out_item.digest_word);
                        errors++;
                    end
                    if (out_item.word_index !== want.word_index) begin
                        $error("word_index: expected %0d, got %0d",
                               want.word_index, out_item.word_index);
                        errors++;
                    end
                    if (out_item.last_word !== want.last_word) begin
                        $error("last_word: expected %0d, got %0d",
                               want.last_word, out_item.last_word);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else begin
            stall_phase <= stall_phase + 1;
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(STALL_NONE, STALL_PERIODIC);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= (stall_phase % 3 == 0);
            endcase
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no transaction for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(input sha1sh_pkg::t_in_item it);
        int gap;
        if (pace_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_message(input int len, input bit end_on_byte,
                                input int noise_pct, output int sent);
        sent = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
                sent++;
            end
            send_item(make_item(8'($urandom_range(0, 255)), 1'b1,
                                end_on_byte && i == len - 1));
            sent++;
        end
        if (!end_on_byte || len == 0) begin
            send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            sent++;
        end
    endtask

    task automatic test_empty_message();
        send_item(make_item(8'hff, 1'b0, 1'b1));
        wait_drained();
    endtask

    task automatic test_end_on_byte_with_idle();
        send_item(make_item("a", 1'b1, 1'b0));
        send_item(make_item(8'h5a, 1'b0, 1'b0));
        send_item(make_item("b", 1'b1, 1'b0));
        send_item(make_item(8'h00, 1'b0, 1'b0));
        send_item(make_item("c", 1'b1, 1'b1));
        wait_drained();
    endtask

    task automatic test_byte_extremes();
        send_item(make_item(8'h00, 1'b1, 1'b0));
        send_item(make_item(8'hff, 1'b1, 1'b0));
        send_item(make_item(8'h80, 1'b1, 1'b0));
        send_item(make_item(8'h7f, 1'b1, 1'b0));
        send_item(make_item(8'ha5, 1'b0, 1'b1));
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        int sent;
        pace_gaps = 1'b0;
        hold_seq <= hold_seq + 1;
        for (int m = 0; m < 3; m++) send_message($urandom_range(3, 10), 1'b1, 0, sent);
        wait_drained();
        pace_gaps = 1'b1;
    endtask

    task automatic test_random_messages();
        int boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int taken;
        int len;
        int pick;
        int sent;
        taken = 0;
        while (taken < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) len = $urandom_range(0, 20);
            else if (pick < 85) len = boundary_lens[$urandom_range(0, 9)];
            else len = $urandom_range(21, 140);
            pace_gaps = ($urandom_range(0, 4) != 0);
            send_message(len, $urandom_range(0, 1), 10, sent);
            taken += sent;
            items_sent += sent;
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        pace_gaps = 1'b1;
        wait_drained();
    endtask

    initial begin
        hash_restart();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_end_on_byte_with_idle();
        test_byte_extremes();
        test_output_backpressure();
        test_random_messages();
        repeat (SETTLE) @(posedge clk);
        if (digest_q.size() != 0) begin
            $error("%0d digest words never arrived", digest_q.size());
            errors++;
        end
        $display("hashed %0d messages (empty, short, block-boundary and long ones,",
                 msgs_hashed);
        $display("%0d random items)", items_sent);
        $display("compared %0d digest words under random input gaps and output stalls",
                 words_checked);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
